/* hw/rtl/chained_hash_set_engine_core_macros.svh */
// Assertion macros used by the chained hash set engine back end.
`ifndef CHAINED_HASH_SET_ENGINE_CORE_MACROS_SVH
`define CHAINED_HASH_SET_ENGINE_CORE_MACROS_SVH

// Checks that a condition implies a property in the same cycle.
`define CHSE_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Checks that a condition implies a property in the next cycle.
`define CHSE_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* hw/rtl/chse_pkg.sv */
// Types, constants and helper functions of the chained hash set engine.
package chse_pkg;

  localparam int unsigned BUCKETS    = 64;
  localparam int unsigned POOL_SLOTS = 256;
  localparam int unsigned BKT_W      = $clog2(BUCKETS);
  localparam int unsigned SLOT_W     = $clog2(POOL_SLOTS);
  localparam int unsigned CNT_W      = SLOT_W + 1;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned BC_W       = 7;
  localparam int unsigned LIM_W      = 9;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned DIV_CNT_W  = $clog2(KEY_W);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CFG_BUCKET_COUNT = 1'b0,
    CFG_ENTRY_LIMIT  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_HOLD
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_INS_A,
    B_INS_B,
    B_WALK_H,
    B_WALK_S,
    B_DEL_A,
    B_DEL_B,
    B_DEL_C,
    B_DEL_D
  } back_state_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic [BKT_W-1:0] bucket;
  } item_t;

  typedef struct packed {
    logic              is_slot;
    logic [SLOT_W-1:0] idx;
  } link_t;

  function automatic logic [BC_W-1:0] eff_buckets(input logic [BC_W-1:0] bc);
    logic [BC_W-1:0] r;
    if (bc == '0) begin
      r = BC_W'(1);
    end else if (bc > BC_W'(BUCKETS)) begin
      r = BC_W'(BUCKETS);
    end else begin
      r = bc;
    end
    return r;
  endfunction

  function automatic logic [LIM_W-1:0] eff_limit(input logic [LIM_W-1:0] lim);
    logic [LIM_W-1:0] r;
    if (lim < LIM_W'(2)) begin
      r = LIM_W'(2);
    end else if (lim > LIM_W'(POOL_SLOTS)) begin
      r = LIM_W'(POOL_SLOTS);
    end else begin
      r = lim;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/chse_front.sv */
// Front end: accepts words, reduces the key to its bucket and queues the item.
module chse_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 mode_i,
  input  logic [chse_pkg::KEY_W-1:0] key_i,
  input  logic [chse_pkg::BC_W-1:0]  bucket_count_i,
  output logic                       q_valid_o,
  output chse_pkg::item_t            q_item_o,
  input  logic                       q_pop_i
);
  import chse_pkg::*;

  front_state_e           state_q, state_d;
  logic [1:0]             mode_q, mode_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [KEY_W-1:0]       shf_q, shf_d;
  logic [BC_W-1:0]        rem_q, rem_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [BC_W:0]          r2;
  logic [BC_W-1:0]        div;
  item_t                  qmem_q [2];
  logic                   wptr_q, rptr_q;
  logic [1:0]             qcnt_q;
  logic                   q_wr;

  assign div       = eff_buckets(bucket_count_i);
  assign full      = (state_q != F_IDLE);
  assign q_valid_o = (qcnt_q != 2'd0);
  assign q_item_o  = qmem_q[rptr_q];

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    key_d   = key_q;
    shf_d   = shf_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    q_wr    = 1'b0;
    r2      = {rem_q, shf_q[KEY_W-1]};
    if (r2 >= {1'b0, div}) begin
      r2 = r2 - {1'b0, div};
    end
    case (state_q)
      F_IDLE: begin
        if (push) begin
          mode_d  = mode_i;
          key_d   = key_i;
          shf_d   = key_i;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        rem_d = r2[BC_W-1:0];
        shf_d = {shf_q[KEY_W-2:0], 1'b0};
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(KEY_W - 1)) begin
          state_d = F_HOLD;
        end
      end
      F_HOLD: begin
        if (qcnt_q != 2'd2) begin
          q_wr    = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      qcnt_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      if (q_wr) begin
        wptr_q <= ~wptr_q;
      end
      if (q_pop_i) begin
        rptr_q <= ~rptr_q;
      end
      qcnt_q <= qcnt_q + {1'b0, q_wr} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    key_q  <= key_d;
    shf_q  <= shf_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    if (q_wr) begin
      qmem_q[wptr_q] <= '{mode: mode_q, key: key_q, bucket: rem_q[BKT_W-1:0]};
    end
  end

endmodule

/* hw/rtl/chse_back.sv */
// Back end: walks and edits the bucket chains and holds the result word.
`include "chained_hash_set_engine_core_macros.svh"
module chse_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  chse_pkg::item_t            q_item_i,
  output logic                       q_pop_o,
  input  logic [chse_pkg::LIM_W-1:0] entry_limit_i,
  output logic                       empty,
  input  logic                       pop,
  output logic                       found_o,
  output logic [1:0]                 status_o,
  output logic [chse_pkg::CNT_W-1:0] stored_count_o
);
  import chse_pkg::*;

  back_state_e       state_q, state_d;
  item_t             item_q, item_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [SLOT_W-1:0] cur_q, cur_d, pos_q, pos_d, nn_q, nn_d;
  link_t             lnk_q, lnk_d;

  logic              res_valid_q, res_found_q, res_set, res_found;
  logic [1:0]        res_status_q, res_status;
  logic [CNT_W-1:0]  res_count_q;

  logic [SLOT_W-1:0] head_mem_q [BUCKETS];
  logic [BUCKETS-1:0] head_vld_q;
  logic              head_re, head_we, head_clr;
  logic [BKT_W-1:0]  head_raddr, head_raddr_q, head_waddr;
  logic [SLOT_W-1:0] head_wdata, head_mem_rd_q, head_rd;

  logic [KEY_W-1:0]  key_mem_q [POOL_SLOTS];
  logic [SLOT_W-1:0] next_mem_q [POOL_SLOTS];
  link_t             par_mem_q [POOL_SLOTS];
  logic              slot_re, key_we, next_we, par_re, par_we;
  logic [SLOT_W-1:0] slot_raddr, key_waddr, next_waddr, par_raddr, par_waddr;
  logic [KEY_W-1:0]  key_wdata, key_rd_q;
  logic [SLOT_W-1:0] next_wdata, next_rd_q;
  link_t             par_wdata, par_rd_q;

  logic [SLOT_W-1:0] last_slot;

  function automatic logic live(input logic [SLOT_W-1:0] s, input logic [CNT_W-1:0] u);
    return (s != '0) && ({1'b0, s} < u);
  endfunction

  assign head_rd   = head_vld_q[head_raddr_q] ? head_mem_rd_q : '0;
  assign last_slot = SLOT_W'(used_q - CNT_W'(1));

  assign empty          = !res_valid_q;
  assign found_o        = res_found_q;
  assign status_o       = res_status_q;
  assign stored_count_o = res_count_q;

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    used_d     = used_q;
    cur_d      = cur_q;
    pos_d      = pos_q;
    nn_d       = nn_q;
    lnk_d      = lnk_q;
    q_pop_o    = 1'b0;
    res_set    = 1'b0;
    res_found  = 1'b0;
    res_status = ST_DONE;
    head_re    = 1'b0;
    head_raddr = q_item_i.bucket;
    head_we    = 1'b0;
    head_clr   = 1'b0;
    head_waddr = item_q.bucket;
    head_wdata = '0;
    slot_re    = 1'b0;
    slot_raddr = '0;
    key_we     = 1'b0;
    key_waddr  = '0;
    key_wdata  = item_q.key;
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    par_re     = 1'b0;
    par_raddr  = '0;
    par_we     = 1'b0;
    par_waddr  = '0;
    par_wdata  = '0;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i && !res_valid_q) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          head_re = 1'b1;
          case (q_item_i.mode)
            MODE_INSERT: begin
              if (used_q >= eff_limit(entry_limit_i)) begin
                res_set    = 1'b1;
                res_status = ST_FULL;
              end else begin
                state_d = B_INS_A;
              end
            end
            MODE_QUERY, MODE_DELETE: begin
              state_d = B_WALK_H;
            end
            default: begin
              head_clr = 1'b1;
              used_d   = CNT_W'(1);
              res_set  = 1'b1;
            end
          endcase
        end
      end
      B_INS_A: begin
        key_we     = 1'b1;
        key_waddr  = used_q[SLOT_W-1:0];
        next_we    = 1'b1;
        next_waddr = used_q[SLOT_W-1:0];
        next_wdata = head_rd;
        head_we    = 1'b1;
        head_wdata = used_q[SLOT_W-1:0];
        par_we     = 1'b1;
        par_waddr  = used_q[SLOT_W-1:0];
        par_wdata  = '{is_slot: 1'b0, idx: SLOT_W'(item_q.bucket)};
        nn_d       = head_rd;
        used_d     = used_q + CNT_W'(1);
        state_d    = B_INS_B;
      end
      B_INS_B: begin
        if (live(nn_q, used_q)) begin
          par_we    = 1'b1;
          par_waddr = nn_q;
          par_wdata = '{is_slot: 1'b1, idx: last_slot};
        end
        res_set = 1'b1;
        state_d = B_IDLE;
      end
      B_WALK_H: begin
        lnk_d = '{is_slot: 1'b0, idx: SLOT_W'(item_q.bucket)};
        if (!live(head_rd, used_q)) begin
          res_set    = 1'b1;
          res_status = (item_q.mode == MODE_DELETE) ? ST_ABSENT : ST_DONE;
          state_d    = B_IDLE;
        end else begin
          slot_re    = 1'b1;
          slot_raddr = head_rd;
          cur_d      = head_rd;
          state_d    = B_WALK_S;
        end
      end
      B_WALK_S: begin
        if (key_rd_q == item_q.key) begin
          pos_d = cur_q;
          nn_d  = next_rd_q;
          if (item_q.mode == MODE_QUERY) begin
            res_set   = 1'b1;
            res_found = 1'b1;
            state_d   = B_IDLE;
          end else begin
            state_d = B_DEL_A;
          end
        end else begin
          lnk_d = '{is_slot: 1'b1, idx: cur_q};
          if (!live(next_rd_q, used_q)) begin
            res_set    = 1'b1;
            res_status = (item_q.mode == MODE_DELETE) ? ST_ABSENT : ST_DONE;
            state_d    = B_IDLE;
          end else begin
            slot_re    = 1'b1;
            slot_raddr = next_rd_q;
            cur_d      = next_rd_q;
          end
        end
      end
      B_DEL_A: begin
        if (lnk_q.is_slot) begin
          next_we    = 1'b1;
          next_waddr = lnk_q.idx;
          next_wdata = nn_q;
        end else begin
          head_we    = 1'b1;
          head_waddr = lnk_q.idx[BKT_W-1:0];
          head_wdata = nn_q;
        end
        if (live(nn_q, used_q)) begin
          par_we    = 1'b1;
          par_waddr = nn_q;
          par_wdata = lnk_q;
        end
        used_d = used_q - CNT_W'(1);
        if (pos_q == last_slot) begin
          res_set   = 1'b1;
          res_found = 1'b1;
          state_d   = B_IDLE;
        end else begin
          state_d = B_DEL_B;
        end
      end
      B_DEL_B: begin
        slot_re    = 1'b1;
        slot_raddr = used_q[SLOT_W-1:0];
        par_re     = 1'b1;
        par_raddr  = used_q[SLOT_W-1:0];
        state_d    = B_DEL_C;
      end
      B_DEL_C: begin
        key_we     = 1'b1;
        key_waddr  = pos_q;
        key_wdata  = key_rd_q;
        next_we    = 1'b1;
        next_waddr = pos_q;
        next_wdata = next_rd_q;
        par_we     = 1'b1;
        par_waddr  = pos_q;
        par_wdata  = par_rd_q;
        state_d    = B_DEL_D;
      end
      B_DEL_D: begin
        if (par_rd_q.is_slot) begin
          next_we    = 1'b1;
          next_waddr = par_rd_q.idx;
          next_wdata = pos_q;
        end else begin
          head_we    = 1'b1;
          head_waddr = par_rd_q.idx[BKT_W-1:0];
          head_wdata = pos_q;
        end
        if (live(next_rd_q, used_q)) begin
          par_we    = 1'b1;
          par_waddr = next_rd_q;
          par_wdata = '{is_slot: 1'b1, idx: pos_q};
        end
        res_set   = 1'b1;
        res_found = 1'b1;
        state_d   = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      used_q      <= CNT_W'(1);
      res_valid_q <= 1'b0;
      head_vld_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (res_set) begin
        res_valid_q <= 1'b1;
      end else if (pop) begin
        res_valid_q <= 1'b0;
      end
      if (head_clr) begin
        head_vld_q <= '0;
      end else if (head_we) begin
        head_vld_q[head_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cur_q  <= cur_d;
    pos_q  <= pos_d;
    nn_q   <= nn_d;
    lnk_q  <= lnk_d;
    if (res_set) begin
      res_found_q  <= res_found;
      res_status_q <= res_status;
      res_count_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem_q[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_mem_rd_q <= head_mem_q[head_raddr];
      head_raddr_q  <= head_raddr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem_q[key_waddr] <= key_wdata;
    end
    if (next_we) begin
      next_mem_q[next_waddr] <= next_wdata;
    end
    if (par_we) begin
      par_mem_q[par_waddr] <= par_wdata;
    end
    if (slot_re) begin
      key_rd_q  <= key_mem_q[slot_raddr];
      next_rd_q <= next_mem_q[slot_raddr];
    end
    if (par_re) begin
      par_rd_q <= par_mem_q[par_raddr];
    end
  end

  `CHSE_ASSERT_IMP(a_used_range, 1'b1, (used_q != '0) && (used_q <= CNT_W'(POOL_SLOTS)), "used count out of range")
  `CHSE_ASSERT_IMP(a_no_overwrite, res_set, !res_valid_q, "result word overwritten")
  `CHSE_ASSERT_IMP(a_pop_legal, q_pop_o, q_valid_i && (state_q == B_IDLE), "queue popped while empty or busy")
  `CHSE_ASSERT_NXT(a_clear_count, head_clr, used_q == CNT_W'(1) && res_valid_q, "clear did not reset count")

endmodule

/* hw/rtl/chained_hash_set_engine_core.sv */
// Top level of the chained hash set engine: configuration registers and the two halves.
//
//   Channel   Direction  Handshake              Payload
//   input     in         push / full            mode_i, key_i
//   result    out        empty / pop            found_o, status_o, stored_count_o
//   config    in         cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// The front takes one word at a time, showing full until it has queued the item: the
// bucket is found by a restoring modulo unit that retires one key bit per cycle. The
// back handles one item at a time, walking each bucket chain slot by slot.
// Reset is immediate: bucket heads carry valid bits, so there is no clearing pass.
// A result word waiting on the output stalls the back only; the front keeps working
// until its two-word queue fills.
module chained_hash_set_engine_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 mode_i,
  input  logic [chse_pkg::KEY_W-1:0] key_i,
  output logic                       empty,
  input  logic                       pop,
  output logic                       found_o,
  output logic [1:0]                 status_o,
  output logic [chse_pkg::CNT_W-1:0] stored_count_o,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [chse_pkg::CFG_W-1:0] cfg_wdata_i
);
  import chse_pkg::*;

  logic [BC_W-1:0]  bucket_count_q;
  logic [LIM_W-1:0] entry_limit_q;
  logic             q_valid, q_pop;
  item_t            q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BC_W'(61);
      entry_limit_q  <= LIM_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BUCKET_COUNT: bucket_count_q <= cfg_wdata_i[BC_W-1:0];
        CFG_ENTRY_LIMIT:  entry_limit_q  <= cfg_wdata_i[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  chse_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .mode_i         (mode_i),
    .key_i          (key_i),
    .bucket_count_i (bucket_count_q),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  chse_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .entry_limit_i  (entry_limit_q),
    .empty          (empty),
    .pop            (pop),
    .found_o        (found_o),
    .status_o       (status_o),
    .stored_count_o (stored_count_o)
  );

endmodule

/* verif/tb_chained_hash_set_engine_core.sv */
// Testbench of the chained hash set engine: random and directed words checked against a predictor.
`timescale 1ns / 1ps

module tb_chained_hash_set_engine_core;
  import chse_pkg::*;

  typedef struct {
    logic       found;
    status_e    status;
    logic [8:0] count;
  } set_word_t;

  class hash_set_scoreboard;
    logic [7:0]  heads[BUCKETS];
    logic [31:0] keys[POOL_SLOTS];
    logic [7:0]  nexts[POOL_SLOTS];
    int unsigned used;
    logic [6:0]  bcount;
    logic [8:0]  limit;
    set_word_t   pending[$];
    int          errors;

    function new();
      foreach (heads[i]) heads[i] = '0;
      foreach (keys[i]) begin
        keys[i] = '0;
        nexts[i] = '0;
      end
      used = 1;
      bcount = 7'd61;
      limit = 9'd256;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [8:0] val);
      if (idx == CFG_BUCKET_COUNT) bcount = val[6:0];
      else limit = val;
    endfunction

    function int unsigned bucket_span();
      if (bcount == 0) return 1;
      if (bcount > BUCKETS) return BUCKETS;
      return bcount;
    endfunction

    function int unsigned slot_cap();
      if (limit < 2) return 2;
      if (limit > POOL_SLOTS) return POOL_SLOTS;
      return limit;
    endfunction

    function int unsigned link_value(int unsigned l);
      if (l < BUCKETS) return heads[l];
      return nexts[l - BUCKETS];
    endfunction

    function void link_write(int unsigned l, int unsigned v);
      if (l < BUCKETS) heads[l] = 8'(v);
      else nexts[l - BUCKETS] = 8'(v);
    endfunction

    function bit locate(logic [31:0] k, output int unsigned l);
      int unsigned s;
      l = k % bucket_span();
      for (int unsigned n = 0; n < used; n++) begin
        s = link_value(l);
        if (s == 0 || s >= used) return 0;
        if (keys[s] == k) return 1;
        l = BUCKETS + s;
      end
      return 0;
    endfunction

    function void redirect(int unsigned from, int unsigned to);
      for (int i = 0; i < BUCKETS; i++)
        if (heads[i] == from) begin
          heads[i] = 8'(to);
          return;
        end
      for (int unsigned i = 1; i < used; i++)
        if (nexts[i] == from) begin
          nexts[i] = 8'(to);
          return;
        end
    endfunction

    function void note(mode_e m, logic [31:0] k);
      set_word_t   w;
      int unsigned l, b, pos, last;
      w.found = 1'b0;
      w.status = ST_DONE;
      case (m)
        MODE_INSERT: begin
          if (used >= slot_cap()) begin
            w.status = ST_FULL;
          end else begin
            b = k % bucket_span();
            keys[used] = k;
            nexts[used] = heads[b];
            heads[b] = 8'(used);
            used++;
          end
        end
        MODE_QUERY: w.found = locate(k, l);
        MODE_DELETE: begin
          if (!locate(k, l)) begin
            w.status = ST_ABSENT;
          end else begin
            pos = link_value(l);
            last = used - 1;
            w.found = 1'b1;
            link_write(l, nexts[pos]);
            used = last;
            if (pos != last) begin
              keys[pos] = keys[last];
              nexts[pos] = nexts[last];
              redirect(last, pos);
            end
          end
        end
        default: begin
          foreach (heads[i]) heads[i] = '0;
          used = 1;
        end
      endcase
      w.count = used[8:0];
      pending.push_back(w);
    endfunction

    function void check(logic f, logic [1:0] s, logic [8:0] c);
      set_word_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word found=%0d status=%0d count=%0d", $time, f, s, c);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (f !== w.found) begin
        $display("%0t: found expected %0d actual %0d", $time, w.found, f);
        errors++;
      end
      if (s !== w.status) begin
        $display("%0t: status expected %0d actual %0d", $time, w.status, s);
        errors++;
      end
      if (c !== w.count) begin
        $display("%0t: stored_count expected %0d actual %0d", $time, w.count, c);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni, push, full, empty, pop;
  logic [1:0]  mode_i;
  logic [31:0] key_i;
  logic        found_o;
  logic [1:0]  status_o;
  logic [8:0]  stored_count_o;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [8:0]  cfg_wdata_i;

  hash_set_scoreboard sb = new();
  int          idle_pct, stall_pct;
  logic [31:0] key_set[24];

  chained_hash_set_engine_core DUT (.*);

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check(found_o, status_o, stored_count_o);
    pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_word(mode_e m, logic [31:0] k);
    push <= 1'b1;
    mode_i <= m;
    key_i <= k;
    do @(posedge clk_i); while (full);
    sb.note(m, k);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [8:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(logic [8:0] bc, logic [8:0] lim, int n, int mode, int ins_pct);
    int          r;
    logic [31:0] k;
    drain();
    write_reg(CFG_BUCKET_COUNT, bc);
    write_reg(CFG_ENTRY_LIMIT, lim);
    idle_pct = (mode == 1) ? 54 : (mode == 3) ? 36 : 0;
    stall_pct = (mode == 2) ? 54 : (mode == 3) ? 36 : 0;
    foreach (key_set[i]) key_set[i] = (i % 2) ? $urandom : $urandom_range(0, 200);
    repeat (n) begin
      r = $urandom_range(0, 99);
      k = ($urandom_range(0, 9) < 7) ? key_set[$urandom_range(0, 23)] : $urandom;
      if (r < ins_pct) send_word(MODE_INSERT, k);
      else if (r == 99) send_word(MODE_CLEAR, k);
      else if (r < ins_pct + (99 - ins_pct) / 2) send_word(MODE_QUERY, k);
      else send_word(MODE_DELETE, k);
    end
  endtask

  initial begin
    #20_000_000;
    $display("tb_chained_hash_set_engine_core: done, errors");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    push <= 1'b0;
    pop <= 1'b0;
    mode_i <= MODE_INSERT;
    key_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_BUCKET_COUNT;
    cfg_wdata_i <= '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default settings: two keys share bucket zero, so the delete moves the last slot.
    send_word(MODE_INSERT, 32'd0);
    send_word(MODE_INSERT, 32'hFFFF_FFFF);
    send_word(MODE_INSERT, 32'd61);
    send_word(MODE_QUERY, 32'd0);
    send_word(MODE_QUERY, 32'd61);
    send_word(MODE_QUERY, 32'd5);
    send_word(MODE_DELETE, 32'd0);
    send_word(MODE_QUERY, 32'd61);
    send_word(MODE_QUERY, 32'd0);
    send_word(MODE_DELETE, 32'd7);
    send_word(MODE_DELETE, 32'hFFFF_FFFF);
    send_word(MODE_CLEAR, 32'hFFFF_FFFF);
    send_word(MODE_QUERY, 32'd61);
    drain();
    write_reg(CFG_ENTRY_LIMIT, 9'd2);
    send_word(MODE_INSERT, 32'd1);
    send_word(MODE_INSERT, 32'd2);
    drain();
    write_reg(CFG_ENTRY_LIMIT, 9'd0);
    send_word(MODE_INSERT, 32'd3);
    send_word(MODE_DELETE, 32'd1);
    send_word(MODE_CLEAR, 32'd0);

    run_phase(9'd64, 9'd256, 200, 0, 70);
    run_phase(9'd1, 9'd40, 150, 1, 50);
    run_phase(9'd0, 9'd511, 150, 2, 50);
    run_phase(9'd127, 9'd256, 350, 3, 80);
    run_phase(9'd7, 9'd256, 300, 0, 90);
    run_phase(9'd13, 9'd1, 150, 1, 40);
    run_phase(9'd33, 9'd20, 150, 2, 50);
    run_phase(9'd61, 9'd256, 200, 3, 50);

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_chained_hash_set_engine_core: done, clean");
    end else begin
      $display("tb_chained_hash_set_engine_core: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/chse_pkg.sv
hw/rtl/chse_front.sv
hw/rtl/chse_back.sv
hw/rtl/chained_hash_set_engine_core.sv
verif/tb_chained_hash_set_engine_core.sv
